// File: sv/track_box_association_defines.svh
// Assertion helpers included by the top-level RTL file
`ifndef TRACK_BOX_ASSOCIATION_DEFINES_SVH
`define TRACK_BOX_ASSOCIATION_DEFINES_SVH

// Same-cycle implication, off during reset
`define TBA_ASSERT_IMPLY(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("tba assertion failed");

// Next-cycle implication, off during reset
`define TBA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("tba assertion failed");

`endif

// File: sv/tba_pkg.sv
`timescale 1ns / 1ps
package tba_pkg;

  localparam int unsigned MaxTracks = 32;
  localparam int unsigned SlotW     = $clog2(MaxTracks);
  localparam int unsigned CoordW    = 12;
  localparam int unsigned FrameW    = 15;
  localparam int unsigned RatioW    = 16;
  localparam int unsigned AreaW     = 2 * CoordW;
  localparam int unsigned D2W       = 27;
  localparam int unsigned DistW     = 14;
  localparam int unsigned QuoW      = RatioW + 1;
  localparam int unsigned SqrtSteps = (D2W + 1) / 2;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned StepW     = 5;

  localparam logic [RatioW-1:0] NearReset    = 16'd13107;
  localparam logic [RatioW-1:0] OverlapReset = 16'd32768;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegNear    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegOverlap = 8'd1;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } box_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic             valid;
    box_t             box;
  } tbl_wr_t;

  typedef struct packed {
    logic             start;
    logic [D2W-1:0]   d2;
    logic [AreaW-1:0] inter;
    logic [AreaW-1:0] area_box;
    logic [AreaW-1:0] area_det;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [DistW-1:0]  root;
    logic [RatioW-1:0] ov0;
    logic [RatioW-1:0] ov1;
  } arith_rsp_t;

endpackage

// File: sv/tba_table.sv
`timescale 1ns / 1ps
module tba_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tba_pkg::tbl_wr_t            wr_i,
  input  logic                        rd_en_i,
  input  logic [tba_pkg::SlotW-1:0]   rd_addr_i,
  output tba_pkg::box_t               rd_box_o,
  output logic                        rd_valid_o
);

  tba_pkg::box_t                     mem [tba_pkg::MaxTracks];
  logic [tba_pkg::MaxTracks-1:0]     vld_q;
  tba_pkg::box_t                     rd_box_q;
  logic                              rd_valid_q;

  // Write box data for a stored entry and register the read data
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.valid) begin
      mem[wr_i.slot] <= wr_i.box;
    end
    if (rd_en_i) begin
      rd_box_q <= mem[rd_addr_i];
    end
  end

  // Track valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.slot] <= wr_i.valid;
      end
      if (rd_en_i) begin
        rd_valid_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_box_o   = rd_box_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// File: sv/tba_arith.sv
`timescale 1ns / 1ps
module tba_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tba_pkg::arith_req_t req_i,
  output tba_pkg::arith_rsp_t rsp_o
);

  localparam int unsigned RemW = tba_pkg::AreaW;

  logic                          busy_q;
  logic [tba_pkg::StepW-1:0]     step_q;
  logic [tba_pkg::D2W-1:0]       v_q, res_q, bit_q;
  logic [RemW-1:0]               rem0_q, rem1_q;
  logic [RemW-1:0]               den0_q, den1_q;
  logic [tba_pkg::QuoW-1:0]      quo0_q, quo1_q;
  logic                          done_q;

  logic [tba_pkg::D2W:0]         sq_try;
  logic [RemW:0]                 t0, t1;

  // One root bit per step while the probe bit is nonzero
  assign sq_try = {1'b0, res_q} + {1'b0, bit_q};

  // Shift the partial remainder, except on the first step
  assign t0 = (step_q == '0) ? {1'b0, rem0_q} : {rem0_q, 1'b0};
  assign t1 = (step_q == '0) ? {1'b0, rem1_q} : {rem1_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == tba_pkg::StepW'(tba_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Square root and both ratio divisions advance together
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q    <= req_i.d2;
      res_q  <= '0;
      bit_q  <= tba_pkg::D2W'(1) << (2 * (tba_pkg::SqrtSteps - 1));
      rem0_q <= req_i.inter;
      rem1_q <= req_i.inter;
      den0_q <= req_i.area_box;
      den1_q <= req_i.area_det;
      quo0_q <= '0;
      quo1_q <= '0;
    end else if (busy_q) begin
      if (bit_q != '0) begin
        if ({1'b0, v_q} >= sq_try) begin
          v_q   <= v_q - sq_try[tba_pkg::D2W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      if (t0 >= {1'b0, den0_q}) begin
        rem0_q <= RemW'(t0 - {1'b0, den0_q});
        quo0_q <= {quo0_q[tba_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem0_q <= t0[RemW-1:0];
        quo0_q <= {quo0_q[tba_pkg::QuoW-2:0], 1'b0};
      end
      if (t1 >= {1'b0, den1_q}) begin
        rem1_q <= RemW'(t1 - {1'b0, den1_q});
        quo1_q <= {quo1_q[tba_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem1_q <= t1[RemW-1:0];
        quo1_q <= {quo1_q[tba_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  // Saturate at one and zero out an empty divisor
  always_comb begin
    rsp_o.done = done_q;
    rsp_o.root = res_q[tba_pkg::DistW-1:0];
    if (den0_q == '0) begin
      rsp_o.ov0 = '0;
    end else if (quo0_q[tba_pkg::QuoW-1]) begin
      rsp_o.ov0 = '1;
    end else begin
      rsp_o.ov0 = quo0_q[tba_pkg::RatioW-1:0];
    end
    if (den1_q == '0) begin
      rsp_o.ov1 = '0;
    end else if (quo1_q[tba_pkg::QuoW-1]) begin
      rsp_o.ov1 = '1;
    end else begin
      rsp_o.ov1 = quo1_q[tba_pkg::RatioW-1:0];
    end
  end

endmodule

// File: sv/track_box_association.sv
// Track box association.
// Input items arrive on the s_axis channel. tuser is the kind: a load writes or
// clears one table slot, a query brings a detected box and the current frame.
// Loads give no result. A query gives one result item on
// m_axis: tuser is the found flag, tdata the slot and overlap ratio.
// A query walks all 32 slots in order, one synchronous table read per slot.
// An empty or stale slot passes StRead, StGeo and StMul only; a live slot
// also waits in StIter on the 17-step shared root and divide unit, then StEval.
// Only one item is worked at a time; a load is accepted while a result waits.
// The user must write registers on the cfg channel only while idle; the block does not enforce it.
// Reset empties the table at once and restores the register defaults.
// When the receiver stalls, the result holds in the output register and a
// following query waits at its end until that result is taken.
`timescale 1ns / 1ps
`include "track_box_association_defines.svh"
module track_box_association (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[4:0], entry_valid[5], box_x[17:6], box_y[29:18], box_w[41:30],
  // box_h[53:42], frame_number[68:54], zero fill above
  input  logic [71:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found_slot[4:0], best_overlap[20:5], zero fill above
  output logic [23:0] m_axis_tdata,
  // found[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [tba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CntW = tba_pkg::SlotW + 1;
  localparam int unsigned CW   = tba_pkg::CoordW;
  localparam int unsigned C2W  = CW + 2;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StRead = 7'b0000010,
    StGeo  = 7'b0000100,
    StMul  = 7'b0001000,
    StIter = 7'b0010000,
    StEval = 7'b0100000,
    StDone = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic [CntW-1:0]                idx_q;
  logic [15:0]                    near_lim_q, ovl_lim_q;
  tba_pkg::box_t                  det_q;
  logic [tba_pkg::RatioW-1:0]     best_q;
  logic [tba_pkg::SlotW-1:0]      best_slot_q;
  logic                           found_q;
  logic                           out_vld_q;
  logic                           out_found_q;
  logic [tba_pkg::SlotW-1:0]      out_slot_q;
  logic [tba_pkg::RatioW-1:0]     out_ovl_q;

  // geometry stage registers
  logic                           skip_q, inside_q;
  logic [CW:0]                    adx_q, ady_q;
  logic [CW-1:0]                  ovx_q, ovy_q, maxw_q, ew_q, eh_q;
  logic [27:0]                    near_rhs_q;

  tba_pkg::tbl_wr_t               tbl_wr;
  tba_pkg::box_t                  rd_box;
  logic                           rd_valid;
  tba_pkg::arith_req_t            areq;
  tba_pkg::arith_rsp_t            arsp;
  tba_pkg::box_t                  in_box;
  logic                           in_acc, last_slot;

  assign in_box.x     = s_axis_tdata[17:6];
  assign in_box.y     = s_axis_tdata[29:18];
  assign in_box.w     = s_axis_tdata[41:30];
  assign in_box.h     = s_axis_tdata[53:42];
  assign in_box.frame = s_axis_tdata[68:54];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign last_slot     = (idx_q == CntW'(tba_pkg::MaxTracks - 1));

  // Load items go straight to the table
  assign tbl_wr.en    = in_acc && (s_axis_tuser == tba_pkg::KindLoad);
  assign tbl_wr.slot  = s_axis_tdata[4:0];
  assign tbl_wr.valid = s_axis_tdata[5];
  assign tbl_wr.box   = in_box;

  tba_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .rd_en_i    (state_q == StRead),
    .rd_addr_i  (idx_q[tba_pkg::SlotW-1:0]),
    .rd_box_o   (rd_box),
    .rd_valid_o (rd_valid)
  );

  // Geometry of the stored box against the detected one
  logic [C2W-1:0] cx2, cy2, bx2, by2, ex2, ey2, exe2, eye2;
  logic [C2W:0]   ddx, ddy, mdx, mdy;
  logic [CW:0]    lox, hix, loy, hiy, dend_x, dend_y, eend_x, eend_y;
  logic           stale, inside_c;
  logic [15:0]    frame_lim;

  always_comb begin
    cx2    = C2W'({det_q.x, 1'b0}) + C2W'(det_q.w);
    cy2    = C2W'({det_q.y, 1'b0}) + C2W'(det_q.h);
    bx2    = C2W'({rd_box.x, 1'b0}) + C2W'(rd_box.w);
    by2    = C2W'({rd_box.y, 1'b0}) + C2W'(rd_box.h);
    ex2    = C2W'({rd_box.x, 1'b0});
    ey2    = C2W'({rd_box.y, 1'b0});
    exe2   = ex2 + C2W'({rd_box.w, 1'b0});
    eye2   = ey2 + C2W'({rd_box.h, 1'b0});
    ddx    = {1'b0, bx2} - {1'b0, cx2};
    ddy    = {1'b0, by2} - {1'b0, cy2};
    mdx    = ddx[C2W] ? (~ddx + 1'b1) : ddx;
    mdy    = ddy[C2W] ? (~ddy + 1'b1) : ddy;
    dend_x = {1'b0, det_q.x} + {1'b0, det_q.w};
    dend_y = {1'b0, det_q.y} + {1'b0, det_q.h};
    eend_x = {1'b0, rd_box.x} + {1'b0, rd_box.w};
    eend_y = {1'b0, rd_box.y} + {1'b0, rd_box.h};
    lox    = (det_q.x > rd_box.x) ? {1'b0, det_q.x} : {1'b0, rd_box.x};
    loy    = (det_q.y > rd_box.y) ? {1'b0, det_q.y} : {1'b0, rd_box.y};
    hix    = (dend_x < eend_x) ? dend_x : eend_x;
    hiy    = (dend_y < eend_y) ? dend_y : eend_y;
    frame_lim = {1'b0, rd_box.frame} + 16'd2;
    stale    = frame_lim < {1'b0, det_q.frame};
    inside_c = (ex2 <= cx2) && (cx2 < exe2) && (ey2 <= cy2) && (cy2 < eye2);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StGeo) begin
      skip_q   <= !rd_valid || stale;
      inside_q <= inside_c;
      adx_q    <= mdx[C2W-1:1];
      ady_q    <= mdy[C2W-1:1];
      ovx_q    <= (hix > lox) ? CW'(hix - lox) : '0;
      ovy_q    <= (hiy > loy) ? CW'(hiy - loy) : '0;
      maxw_q   <= (det_q.w > rd_box.w) ? det_q.w : rd_box.w;
      ew_q     <= rd_box.w;
      eh_q     <= rd_box.h;
    end
    if (state_q == StMul) begin
      near_rhs_q <= 28'(near_lim_q * maxw_q);
    end
  end

  // Products feed the shared root and divide unit, live entries only
  assign areq.start    = (state_q == StMul) && !skip_q;
  assign areq.d2       = tba_pkg::D2W'(adx_q * adx_q) + tba_pkg::D2W'(ady_q * ady_q);
  assign areq.inter    = tba_pkg::AreaW'(ovx_q * ovy_q);
  assign areq.area_box = tba_pkg::AreaW'(ew_q * eh_q);
  assign areq.area_det = tba_pkg::AreaW'(det_q.w * det_q.h);

  tba_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .rsp_o  (arsp)
  );

  // Qualify the entry and keep the strictly larger overlap
  logic                         near_c, qual_c;
  logic [tba_pkg::RatioW-1:0]   best_c;
  logic [tba_pkg::SlotW-1:0]    slot_c;
  logic                         found_c;

  always_comb begin
    near_c  = {arsp.root, 16'b0} < {2'b0, near_rhs_q};
    qual_c  = inside_q && (near_c || (arsp.ov0 > ovl_lim_q) || (arsp.ov1 > ovl_lim_q));
    best_c  = best_q;
    slot_c  = best_slot_q;
    found_c = found_q;
    if (qual_c && (arsp.ov0 > best_c)) begin
      best_c  = arsp.ov0;
      slot_c  = idx_q[tba_pkg::SlotW-1:0];
      found_c = 1'b1;
    end
    if (qual_c && (arsp.ov1 > best_c)) begin
      best_c  = arsp.ov1;
      slot_c  = idx_q[tba_pkg::SlotW-1:0];
      found_c = 1'b1;
    end
  end

  // Sequence the walk over the table
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc && (s_axis_tuser == tba_pkg::KindQuery)) state_d = StRead;
      StRead: state_d = StGeo;
      StGeo:  state_d = StMul;
      StMul: begin
        if (skip_q) begin
          state_d = last_slot ? StDone : StRead;
        end else begin
          state_d = StIter;
        end
      end
      StIter: if (arsp.done) state_d = StEval;
      StEval: state_d = last_slot ? StDone : StRead;
      StDone: if (!out_vld_q || m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      near_lim_q  <= tba_pkg::NearReset;
      ovl_lim_q   <= tba_pkg::OverlapReset;
      best_q      <= '0;
      best_slot_q <= '0;
      found_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == tba_pkg::RegNear) near_lim_q <= cfg_data_i;
        if (cfg_index_i == tba_pkg::RegOverlap) ovl_lim_q <= cfg_data_i;
      end
      if (state_q == StIdle) begin
        idx_q       <= '0;
        best_q      <= '0;
        best_slot_q <= '0;
        found_q     <= 1'b0;
      end
      if (state_q == StEval) begin
        best_q      <= best_c;
        best_slot_q <= slot_c;
        found_q     <= found_c;
      end
      if ((state_q == StEval) || ((state_q == StMul) && skip_q)) begin
        idx_q <= idx_q + 1'b1;
      end
      if ((state_q == StDone) && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture the detected box and the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) det_q <= in_box;
    if ((state_q == StDone) && (!out_vld_q || m_axis_tready)) begin
      out_found_q <= found_q;
      out_slot_q  <= best_slot_q;
      out_ovl_q   <= best_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {3'b0, out_ovl_q, out_slot_q};

  `TBA_ASSERT_IMPLY(a_idx_range, clk_i, rst_ni, state_q != StIdle && state_q != StDone,
                    idx_q < CntW'(tba_pkg::MaxTracks))
  `TBA_ASSERT_IMPLY(a_done_in_iter, clk_i, rst_ni, arsp.done, state_q == StIter)
  `TBA_ASSERT_IMPLY(a_found_has_overlap, clk_i, rst_ni, found_q, best_q != '0)
  `TBA_ASSERT_IMPLY(a_miss_is_zero, clk_i, rst_ni, state_q == StDone && !found_q,
                    best_slot_q == '0 && best_q == '0)
  `TBA_ASSERT_NEXT(a_eval_moves_on, clk_i, rst_ni, state_q == StEval,
                   state_q == StRead || state_q == StDone)

endmodule

// File: tb/sv/track_box_association_checker.sv
`timescale 1ns / 1ps
module track_box_association_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [tba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import tba_pkg::*;

  typedef struct {
    logic        found;
    logic [4:0]  slot;
    logic [15:0] overlap;
  } match_t;

  typedef struct {
    bit          live;
    logic [11:0] x, y, w, h;
    logic [14:0] frame;
  } track_t;

  track_t      tracks [MaxTracks];
  logic [15:0] near_lim, ovl_lim;
  match_t      match_q[$];

  assign pending_o = match_q.size();

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 15; b >= 0; b--)
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r += 64'd1 << b;
    return r;
  endfunction

  function automatic longint unsigned q16_ratio(longint unsigned num, longint unsigned den);
    longint unsigned r;
    if (den == 0) return 0;
    r = (num << 16) / den;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic longint overlap_span(longint a, longint al, longint b, longint bl);
    longint lo, hi;
    lo = (a > b) ? a : b;
    hi = ((a + al) < (b + bl)) ? a + al : b + bl;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Scan the table for the best overlapping live track
  function automatic match_t best_match(longint x, longint y, longint w, longint h,
                                        longint fr);
    match_t m;
    longint cx2, cy2, bx, by, bw, bh, dx, dy, maxw, inter;
    longint unsigned root_len, ov0, ov1, best;
    bit near_ok, in_box;
    best = 0;
    m.found = 0; m.slot = 0; m.overlap = 0;
    cx2 = 2 * x + w;
    cy2 = 2 * y + h;
    for (int j = 0; j < MaxTracks; j++) begin
      if (!tracks[j].live || longint'(tracks[j].frame) < fr - 2) continue;
      bx = tracks[j].x; by = tracks[j].y; bw = tracks[j].w; bh = tracks[j].h;
      dx = (2 * bx + bw - cx2) / 2;
      dy = (2 * by + bh - cy2) / 2;
      root_len = floor_root(dx * dx + dy * dy);
      maxw = (w > bw) ? w : bw;
      near_ok = root_len * 65536 < longint'(near_lim) * maxw;
      inter = overlap_span(x, w, bx, bw) * overlap_span(y, h, by, bh);
      ov0 = q16_ratio(inter, bw * bh);
      ov1 = q16_ratio(inter, w * h);
      in_box = (2 * bx <= cx2) && (cx2 < 2 * bx + 2 * bw) &&
               (2 * by <= cy2) && (cy2 < 2 * by + 2 * bh);
      if (in_box && (near_ok || ov0 > ovl_lim || ov1 > ovl_lim)) begin
        if (ov0 > best) begin best = ov0; m.found = 1; m.slot = 5'(j); end
        if (ov1 > best) begin best = ov1; m.found = 1; m.slot = 5'(j); end
      end
    end
    m.overlap = 16'(best);
    return m;
  endfunction

  // Track config and table writes, predict and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    match_t exp_m;
    logic [71:0] d;
    if (!rst_ni) begin
      foreach (tracks[i]) tracks[i] = '{0, 0, 0, 0, 0, 0};
      near_lim     <= NearReset;
      ovl_lim      <= OverlapReset;
      match_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegNear) near_lim <= cfg_data_i;
        else if (cfg_index_i == RegOverlap) ovl_lim <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (match_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_m = match_q.pop_front();
          if (m_axis_tuser !== exp_m.found || m_axis_tdata[4:0] !== exp_m.slot ||
              m_axis_tdata[20:5] !== exp_m.overlap || m_axis_tdata[23:21] !== 3'b0) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: exp found=%0d slot=%0d ovl=%0d got found=%0d slot=%0d ovl=%0d",
                       exp_m.found, exp_m.slot, exp_m.overlap, m_axis_tuser,
                       m_axis_tdata[4:0], m_axis_tdata[20:5]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        d = s_axis_tdata;
        if (s_axis_tuser == KindLoad) begin
          tracks[d[4:0]].live  = d[5];
          tracks[d[4:0]].x     = d[5] ? d[17:6]  : '0;
          tracks[d[4:0]].y     = d[5] ? d[29:18] : '0;
          tracks[d[4:0]].w     = d[5] ? d[41:30] : '0;
          tracks[d[4:0]].h     = d[5] ? d[53:42] : '0;
          tracks[d[4:0]].frame = d[5] ? d[68:54] : '0;
        end else begin
          match_q = {match_q, best_match(d[17:6], d[29:18], d[41:30], d[53:42],
                                         d[68:54])};
        end
      end
    end
  end
endmodule

// File: tb/sv/track_box_association_test.sv
`timescale 1ns / 1ps
module track_box_association_test;
  import tba_pkg::*;

  logic        clk_i = 0, rst_ni = 0;
  logic        s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 0, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          send_idle, recv_stall;
  int unsigned cycles;
  logic [14:0] cur_frame;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  track_box_association dut (.*);
  track_box_association_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  // Stall the result channel at the phase's rate
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 6_000_000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold valid high only while an item is offered
  task automatic send_item(logic kind, logic [4:0] slot, logic ev, logic [11:0] x,
                           logic [11:0] y, logic [11:0] w, logic [11:0] h,
                           logic [14:0] fr);
    cfg_valid_i <= 0;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b0, fr, h, w, y, x, ev, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    cfg_valid_i   <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  // Load a track near a random point, then query around it
  task automatic tracked_burst(int n);
    logic [11:0] x, y, w, h;
    logic [4:0]  s;
    for (int i = 0; i < n; i++) begin
      x = 12'($urandom_range(3000)); y = 12'($urandom_range(3000));
      w = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 300));
      h = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 300));
      s = 5'($urandom);
      if ($urandom_range(3) == 0) cur_frame = 15'(cur_frame + $urandom_range(3));
      if ($urandom_range(2) == 0)
        send_item(KindLoad, s, $urandom_range(7) != 0, x, y, w, h,
                  15'(cur_frame - $urandom_range(4)));
      else if ($urandom_range(9) == 0)
        send_item(1'($urandom), 5'($urandom), 1'($urandom), 12'($urandom),
                  12'($urandom), 12'($urandom), 12'($urandom), 15'($urandom));
      else
        send_item(KindQuery, 5'($urandom), 1'($urandom),
                  12'(x + $urandom_range(40) - 20), 12'(y + $urandom_range(40) - 20),
                  12'(w + $urandom_range(20) - 10), 12'(h + $urandom_range(20) - 10),
                  cur_frame);
    end
  endtask

  initial begin
    send_idle = 0; recv_stall = 0; cur_frame = 100;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, zero area, full overlap, stale entry, clear
    send_item(KindQuery, 0, 0, 0, 0, 0, 0, 0);
    send_item(KindLoad, 0, 1, 100, 100, 50, 50, 100);
    send_item(KindLoad, 1, 1, 100, 100, 50, 50, 97);
    send_item(KindLoad, 2, 1, 110, 110, 40, 40, 100);
    send_item(KindLoad, 3, 1, 120, 120, 0, 0, 100);
    send_item(KindLoad, 31, 1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 15'h7FFF);
    send_item(KindQuery, 5, 1, 100, 100, 50, 50, 100);
    send_item(KindQuery, 0, 0, 112, 112, 30, 30, 101);
    send_item(KindQuery, 31, 1, 120, 120, 0, 0, 100);
    send_item(KindQuery, 0, 0, 0, 0, 0, 0, 15'h7FFF);
    send_item(KindQuery, 0, 0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 15'h7FFF);
    send_item(KindQuery, 0, 0, 125, 125, 2, 2, 100);
    send_item(KindLoad, 0, 0, 12'hFFF, 0, 0, 0, 0);
    send_item(KindQuery, 0, 0, 100, 100, 50, 50, 102);
    drain();
    write_reg(RegOverlap, 16'hFFFF);
    write_reg(RegNear, 16'hFFFF);
    write_reg(8'd7, 16'h1234);
    send_item(KindQuery, 0, 0, 110, 110, 40, 40, 100);
    send_item(KindQuery, 0, 0, 128, 128, 4, 4, 100);
    drain();
    write_reg(RegNear, 16'd0);
    write_reg(RegOverlap, 16'd0);
    send_item(KindQuery, 0, 0, 110, 110, 40, 40, 100);
    send_item(KindQuery, 0, 0, 150, 150, 60, 60, 100);
    drain();

    // Random phases under various idle patterns and limits
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 80; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 80; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      write_reg(RegNear, (p == 5) ? 16'hFFFF : 16'($urandom_range(30000)));
      write_reg(RegOverlap, (p == 4) ? 16'd0 : 16'($urandom));
      tracked_burst(237);
      drain();
    end
    send_idle = 0; recv_stall = 0;
    write_reg(RegNear, NearReset);
    write_reg(RegOverlap, OverlapReset);
    tracked_burst(20);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/tba_pkg.sv
sv/tba_table.sv
sv/tba_arith.sv
sv/track_box_association.sv
tb/sv/track_box_association_checker.sv
tb/sv/track_box_association_test.sv
